[rtl/sha256_stream_hash_assert.svh]
// assertion macros for the sha-256 stream hash
// used by the top level and the round unit
`ifndef SHA256_STREAM_HASH_ASSERT_SVH
`define SHA256_STREAM_HASH_ASSERT_SVH

// implication checked at every clock edge outside reset
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/sha_pkg.sv]
// shared types, constants and functions for the sha-256 stream hash
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned PadLimit   = 56;
    localparam logic [7:0]  PadByte    = 8'h80;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_LEN   = 7'b0000100,
        ST_LOAD  = 7'b0001000,
        ST_RUN   = 7'b0010000,
        ST_FOLD  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    // control from the sequencer into the round unit
    typedef struct packed {
        logic start;
        logic restart;
    } rnd_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rnd_stat_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[rtl/sha_round.sv]
// sha-256 compression: one round per cycle over a 16-word schedule window
// depends on sha_pkg; words are loaded serially before start
`timescale 1ns / 1ps
`default_nettype none

`include "sha256_stream_hash_assert.svh"

module sha_round
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire sha_pkg::rnd_ctrl_t ctrl,
    input  wire                 load_en,
    input  wire sha_pkg::word_t load_word,
    input  wire  [2:0]          hash_idx,
    output sha_pkg::word_t      hash_word,
    output sha_pkg::rnd_stat_t  stat
);

    sha_pkg::word_t w_reg [16];
    sha_pkg::word_t h_reg [8];
    sha_pkg::word_t v_reg [8];
    logic [5:0]     t_reg;
    logic           run_reg;
    logic           done_reg;

    function automatic sha_pkg::word_t rotr(input sha_pkg::word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    sha_pkg::word_t s0, s1, w_new, e1, ch, t1, a0, maj;

    always_comb
    begin
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        e1    = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + e1 + ch + sha_pkg::round_k(t_reg) + w_reg[0];
        a0    = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            t_reg    <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::init_hash(3'(i));
                v_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.restart)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= sha_pkg::init_hash(3'(i));
            end
            if (ctrl.start)
            begin
                run_reg <= 1'b1;
                t_reg   <= '0;
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            else if (run_reg)
            begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + a0 + maj;
                t_reg    <= t_reg + 6'd1;
                if (t_reg == 6'd63)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (done_reg)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    // schedule window shifts on load and on every round
    always_ff @(posedge clk)
    begin
        if (load_en || (run_reg && !ctrl.start))
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= load_en ? load_word : w_new;
        end
    end

    assign hash_word = h_reg[hash_idx];
    assign stat.busy = run_reg || done_reg;
    assign stat.done = done_reg;

    `SHA_ASSERT_NEXT(a_done_after_last, clk, rst_n, run_reg && t_reg == 6'd63 && !ctrl.start,
                     done_reg)
    `SHA_ASSERT_IMPL(a_no_load_in_run, clk, rst_n, run_reg, !load_en)
    `SHA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)

endmodule

`default_nettype wire

[rtl/sha256_stream_hash.sv]
// top level: byte intake, padding sequencer and digest output
// depends on sha_pkg and sha_round
//
// channel  dir  signals               payload
// s_axis   in   tvalid tready tdata   message_byte [7:0]
//               tuser tlast           byte_present, end_of_message
// m_axis   out  tvalid tready tdata   digest_word [31:0], word_index [34:32]
//               tlast                 last_word
//
// a byte request is taken whenever the sequencer is idle, that is while the block is filling
// a full block stalls the input through the load, round and fold states
// end of message writes 0x80, zeros and length one byte a cycle (up to 64 per block),
// runs one or two compressions, then holds 8 digest words until taken
// reset clears the sequencer and reloads the initial hash values at once
`timescale 1ns / 1ps
`default_nettype none

`include "sha256_stream_hash_assert.svh"

module sha256_stream_hash
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // message_byte
    input  wire         s_axis_tuser,   // byte_present
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word, word_index, zeros
    output logic        m_axis_tlast
);

    sha_pkg::state_t    state_reg, state_next;
    sha_pkg::word_t     blk_reg [16];
    logic [5:0]         fill_reg;
    logic [60:0]        count_reg;
    logic               fin_reg;
    logic               pad_reg;
    // set once the length has gone into the final block
    logic               bits_done_reg;
    logic [4:0]         ld_reg;
    logic [2:0]         idx_reg;
    sha_pkg::word_t     rd_reg;
    logic [63:0]        bits;
    sha_pkg::rnd_ctrl_t ctrl;
    sha_pkg::rnd_stat_t stat;
    sha_pkg::word_t     hash_word;
    logic               acc;
    logic               wr_en;
    logic [5:0]         wr_addr;
    logic [7:0]         wr_data;
    logic               load_en;

    assign acc  = s_axis_tvalid && s_axis_tready;
    assign bits = {count_reg, 3'b000};
    assign s_axis_tready = (state_reg == sha_pkg::ST_IDLE);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg;
        wr_data = s_axis_tdata;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
                wr_en = acc && s_axis_tuser;
            sha_pkg::ST_PAD:
            begin
                wr_en   = 1'b1;
                wr_data = pad_reg ? 8'h00 : sha_pkg::PadByte;
            end
            sha_pkg::ST_LEN:
            begin
                wr_en   = 1'b1;
                wr_data = 8'(bits >> (8 * (63 - int'(fill_reg))));
            end
            default: wr_en = 1'b0;
        endcase
    end

    // block held as big-endian words, one byte lane written per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            blk_reg[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
        rd_reg <= blk_reg[ld_reg[3:0]];
    end

    assign load_en = (state_reg == sha_pkg::ST_LOAD) && ld_reg != 5'd0;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
                if (acc)
                begin
                    if (s_axis_tuser && fill_reg == 6'd63)
                        state_next = sha_pkg::ST_LOAD;
                    else if (s_axis_tlast)
                        state_next = sha_pkg::ST_PAD;
                end
            sha_pkg::ST_PAD:
                if (fill_reg == 6'd63)
                    state_next = sha_pkg::ST_LOAD;
                else if (fill_reg == 6'(sha_pkg::PadLimit - 1))
                    state_next = sha_pkg::ST_LEN;
            sha_pkg::ST_LEN:
                if (fill_reg == 6'd63)
                    state_next = sha_pkg::ST_LOAD;
            sha_pkg::ST_LOAD:
                if (ld_reg == 5'd16)
                begin
                    state_next = sha_pkg::ST_RUN;
                    ctrl.start = 1'b1;
                end
            sha_pkg::ST_RUN:
                if (stat.done)
                    state_next = sha_pkg::ST_FOLD;
            sha_pkg::ST_FOLD:
                if (fin_reg == 1'b0)
                    state_next = sha_pkg::ST_IDLE;
                else if (bits_done_reg)
                    state_next = sha_pkg::ST_EMIT;
                else
                    state_next = sha_pkg::ST_PAD;
            sha_pkg::ST_EMIT:
                if (m_axis_tready && idx_reg == 3'd7)
                begin
                    state_next   = sha_pkg::ST_IDLE;
                    ctrl.restart = 1'b1;
                end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha_pkg::ST_IDLE;
            fill_reg      <= '0;
            count_reg     <= '0;
            fin_reg       <= 1'b0;
            pad_reg       <= 1'b0;
            ld_reg        <= '0;
            idx_reg       <= '0;
            bits_done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
                fill_reg <= fill_reg + 6'd1;
            unique case (state_reg)
                sha_pkg::ST_IDLE:
                    if (acc)
                    begin
                        if (s_axis_tuser)
                            count_reg <= count_reg + 61'd1;
                        fin_reg <= s_axis_tlast;
                    end
                sha_pkg::ST_PAD:
                    pad_reg <= 1'b1;
                sha_pkg::ST_LEN:
                    if (fill_reg == 6'd63)
                        bits_done_reg <= 1'b1;
                sha_pkg::ST_LOAD:
                    ld_reg <= (ld_reg == 5'd16) ? 5'd0 : ld_reg + 5'd1;
                sha_pkg::ST_EMIT:
                    if (m_axis_tready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            count_reg     <= '0;
                            fill_reg      <= '0;
                            fin_reg       <= 1'b0;
                            pad_reg       <= 1'b0;
                            bits_done_reg <= 1'b0;
                        end
                    end
                default: ;
            endcase
        end
    end

    sha_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .load_en   (load_en),
        .load_word (rd_reg),
        .hash_idx  (idx_reg),
        .hash_word (hash_word),
        .stat      (stat)
    );

    assign m_axis_tvalid = (state_reg == sha_pkg::ST_EMIT);
    assign m_axis_tdata  = {5'b0, idx_reg, hash_word};
    assign m_axis_tlast  = (idx_reg == 3'd7);

    `SHA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, stat.busy, !s_axis_tready)
    `SHA_ASSERT_IMPL(a_emit_idle_unit, clk, rst_n, m_axis_tvalid, !stat.busy)
    `SHA_ASSERT_NEXT(a_fold_after_done, clk, rst_n, stat.done, state_reg == sha_pkg::ST_FOLD)

endmodule

`default_nettype wire
